// ===== hdl/sfsa_pkg.sv =====
// Shared types, constants and helper functions for the spreading factor slot admission block.
`timescale 1ns / 1ps

package sfsa_pkg;

	localparam int DATA_W = 32;

	localparam logic [1:0] KIND_CONNECT = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_RELOAD = 2'd2;

	localparam logic [31:0] RESET_HYPER = 32'd1024;
	localparam logic [3:0] RESET_MAX_FACTOR = 4'd12;

	localparam logic [0:0] CFG_HYPER = 1'd0;
	localparam logic [0:0] CFG_MAX_FACTOR = 1'd1;

	localparam logic [3:0] MIN_FACTOR = 4'd7;
	localparam logic [3:0] TOP_FACTOR = 4'd12;
	localparam logic [3:0] NO_FACTOR = 4'd13;

	localparam logic [1:0] BOP_NOP = 2'd0;
	localparam logic [1:0] BOP_RELOAD = 2'd1;
	localparam logic [1:0] BOP_DEBIT = 2'd2;
	localparam logic [1:0] BOP_CREDIT = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] distance;
		logic [31:0] period;
		logic [3:0] release_factor;
	} req_t;

	typedef struct packed {
		logic accepted;
		logic [3:0] assigned_factor;
		logic [31:0] demand;
		logic [31:0] remaining;
	} rsp_t;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] idx;
	} bud_cmd_t;

	typedef struct packed {
		logic covers;
		logic [31:0] new_val;
	} bud_sts_t;

	function automatic logic [3:0] least_factor(input logic [15:0] d);
		logic [3:0] f;
		if (d < 16'd125) f = 4'd7;
		else if (d < 16'd250) f = 4'd8;
		else if (d < 16'd500) f = 4'd9;
		else if (d < 16'd1000) f = 4'd10;
		else if (d < 16'd2000) f = 4'd11;
		else if (d < 16'd4000) f = 4'd12;
		else f = NO_FACTOR;
		return f;
	endfunction

	function automatic logic [3:0] period_limit(input logic [31:0] p);
		logic [3:0] f;
		if (p > 32'd3200) f = 4'd12;
		else if (p > 32'd1600) f = 4'd11;
		else if (p > 32'd800) f = 4'd10;
		else if (p > 32'd400) f = 4'd9;
		else if (p > 32'd200) f = 4'd8;
		else if (p > 32'd100) f = 4'd7;
		else f = 4'd0;
		return f;
	endfunction

endpackage

// ===== hdl/sfsa_div.sv =====
// Serial restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module sfsa_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] dividend,
	input logic [31:0] divisor,
	output logic done,
	output logic [31:0] quotient
);
	import sfsa_pkg::*;

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] shifted;
	logic [33:0] trial;
	logic ge;

	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge = ~trial[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 5'd0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[31:0] : shifted[31:0];
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/sfsa_budget.sv =====
// Free-slot budget store with one shared add and subtract unit for debits and credits.
`timescale 1ns / 1ps

module sfsa_budget #(
	parameter int NUM_FACTORS = 6,
	parameter int IDX_W = 3
) (
	input logic clk,
	input logic arst_n,
	input sfsa_pkg::bud_cmd_t cmd,
	input logic [31:0] hyperperiod,
	input logic [31:0] dem,
	output sfsa_pkg::bud_sts_t sts
);
	import sfsa_pkg::*;

	logic [31:0] slots_q [NUM_FACTORS];
	logic [IDX_W-1:0] idx;
	logic in_range;
	logic [31:0] cur;
	logic sub;
	logic [32:0] operand;
	logic [32:0] res;

	assign idx = cmd.idx[IDX_W-1:0];
	assign in_range = ({29'd0, cmd.idx} < 32'(NUM_FACTORS));
	assign cur = in_range ? slots_q[idx] : '0;
	assign sub = (cmd.op == BOP_DEBIT);
	assign operand = sub ? ~{1'b0, dem} : {1'b0, dem};
	assign res = {1'b0, cur} + operand + {32'd0, sub};

	always_comb begin
		sts.covers = sub & ~res[32];
		if (sub) sts.new_val = res[31:0];
		else sts.new_val = res[32] ? '1 : res[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FACTORS; i++) slots_q[i] <= RESET_HYPER >> i;
		end else begin
			unique case (cmd.op)
				BOP_RELOAD: begin
					for (int i = 0; i < NUM_FACTORS; i++) slots_q[i] <= hyperperiod >> i;
				end
				BOP_DEBIT: begin
					if (in_range && sts.covers) slots_q[idx] <= sts.new_val;
				end
				BOP_CREDIT: begin
					if (in_range) slots_q[idx] <= sts.new_val;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/spreading_factor_slot_admission.sv =====
// Top level of the spreading factor slot admission block with its request sequencer.
// A connect or release first runs a serial divide of the hyperperiod by the period to form
// the demand; a connect then scans one budget per cycle, a release credits one budget.
// Reload requests, zero-period requests and unknown kinds skip the divide and respond directly.
// One request is in work at a time; a new request is stalled until the sequencer is idle again.
// Reset is asynchronous and active low and loads every budget from the reset hyperperiod.
`timescale 1ns / 1ps

module spreading_factor_slot_admission #(
	parameter int NUM_FACTORS = 6
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input sfsa_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output sfsa_pkg::rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [31:0] cfg_data
);
	import sfsa_pkg::*;

	localparam int IDX_W = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_CREDIT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [31:0] hyper_q;
	logic [3:0] max_factor_q;
	logic [1:0] kind_q;
	logic [3:0] f_q;
	logic [3:0] lim_q;
	logic [3:0] rfac_q;
	rsp_t res_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic req_fire;
	logic div_start;
	logic div_done;
	logic [31:0] quotient;
	logic [3:0] plim;
	logic [3:0] lim;
	logic scan_hit;
	logic credit_ok;
	bud_cmd_t bcmd;
	bud_sts_t bsts;

	function automatic logic has_budget(input logic [3:0] f);
		logic [3:0] fo;
		fo = f - MIN_FACTOR;
		return (f >= MIN_FACTOR) && (f <= TOP_FACTOR) && (fo < 4'(NUM_FACTORS));
	endfunction

	function automatic logic [2:0] bud_idx(input logic [3:0] f);
		logic [3:0] fo;
		fo = f - MIN_FACTOR;
		return fo[2:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign req_fire = req_valid && !req_stall;
	assign div_start = req_fire && (req.kind == KIND_CONNECT || req.kind == KIND_RELEASE)
		&& (req.period != 32'd0);
	assign plim = period_limit(req.period);
	assign lim = (max_factor_q < plim) ? max_factor_q : plim;
	assign scan_hit = (state_q == ST_SCAN) && (f_q <= lim_q) && has_budget(f_q) && bsts.covers;
	assign credit_ok = has_budget(rfac_q);

	always_comb begin
		bcmd.op = BOP_NOP;
		bcmd.idx = '0;
		if (req_fire && req.kind == KIND_RELOAD) begin
			bcmd.op = BOP_RELOAD;
		end else if (state_q == ST_SCAN && f_q <= lim_q && has_budget(f_q)) begin
			bcmd.op = BOP_DEBIT;
			bcmd.idx = bud_idx(f_q);
		end else if (state_q == ST_CREDIT && credit_ok) begin
			bcmd.op = BOP_CREDIT;
			bcmd.idx = bud_idx(rfac_q);
		end
	end

	sfsa_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(hyper_q),
		.divisor(req.period),
		.done(div_done),
		.quotient(quotient)
	);

	sfsa_budget #(
		.NUM_FACTORS(NUM_FACTORS),
		.IDX_W(IDX_W)
	) u_budget (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(bcmd),
		.hyperperiod(hyper_q),
		.dem(res_q.demand),
		.sts(bsts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyper_q <= RESET_HYPER;
			max_factor_q <= RESET_MAX_FACTOR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HYPER: hyper_q <= cfg_data;
				CFG_MAX_FACTOR: max_factor_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) state_q <= div_start ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (div_done) state_q <= (kind_q == KIND_CONNECT) ? ST_SCAN : ST_CREDIT;
				end
				ST_SCAN: begin
					if (scan_hit || f_q > lim_q) state_q <= ST_DONE;
				end
				ST_CREDIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q <= req.kind;
			f_q <= least_factor(req.distance);
			lim_q <= lim;
			rfac_q <= req.release_factor;
			res_q <= '0;
		end
		if (state_q == ST_DIV && div_done) res_q.demand <= quotient;
		if (state_q == ST_SCAN) begin
			if (scan_hit) begin
				res_q.accepted <= 1'b1;
				res_q.assigned_factor <= f_q;
				res_q.remaining <= bsts.new_val;
			end else if (f_q <= lim_q) begin
				f_q <= f_q + 4'd1;
			end
		end
		if (state_q == ST_CREDIT && credit_ok) begin
			res_q.accepted <= 1'b1;
			res_q.assigned_factor <= rfac_q;
			res_q.remaining <= bsts.new_val;
		end
		if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after taking a request");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.accepted |-> rsp.remaining == 32'd0 && rsp.assigned_factor == 4'd0)
		else $error("rejected response carries a factor or a budget value");

	a_grant_factor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.accepted |-> rsp.assigned_factor >= MIN_FACTOR
		&& rsp.assigned_factor <= TOP_FACTOR)
		else $error("granted factor outside the budget range");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> f_q <= NO_FACTOR)
		else $error("factor scan ran past its end");

endmodule

// ===== bench/spreading_factor_slot_admission_tb.sv =====
// Self-checking testbench for the spreading factor slot admission block.
`timescale 1ns / 1ps

module spreading_factor_slot_admission_tb;
	import sfsa_pkg::*;

	localparam int N_FAC = 6;
	localparam int LATENCY = 50;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = CFG_HYPER;
	logic [31:0] cfg_data = '0;

	logic [31:0] hyper_m;
	logic [3:0] max_fac_m;
	logic [31:0] slots_m [N_FAC];
	rsp_t expected_q [$];
	int errors = 0;
	bit quiet = 1'b0;
	int stall_left = 0;

	spreading_factor_slot_admission #(
		.NUM_FACTORS(N_FAC)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void refill_budgets();
		for (int i = 0; i < N_FAC; i++) slots_m[i] = hyper_m >> i;
	endfunction

	function automatic int lowest_factor(input logic [15:0] d);
		int f;
		int bound;
		f = MIN_FACTOR;
		bound = 125;
		while (f <= TOP_FACTOR && d >= bound) begin
			f++;
			bound *= 2;
		end
		return f;
	endfunction

	function automatic int highest_factor(input logic [31:0] p);
		int f;
		int bound;
		f = TOP_FACTOR;
		bound = 3200;
		while (f >= MIN_FACTOR && p <= bound) begin
			f--;
			bound /= 2;
		end
		return (f < MIN_FACTOR) ? 0 : f;
	endfunction

	function automatic rsp_t admission_outcome(input req_t r);
		rsp_t o;
		int f;
		int lim;
		int idx;
		logic [32:0] sum;
		o = '0;
		if (r.kind == KIND_RELOAD) begin
			refill_budgets();
		end else if ((r.kind == KIND_CONNECT || r.kind == KIND_RELEASE) && r.period != 0) begin
			o.demand = hyper_m / r.period;
			if (r.kind == KIND_CONNECT) begin
				lim = highest_factor(r.period);
				if (max_fac_m < lim) lim = max_fac_m;
				for (f = lowest_factor(r.distance); f <= lim && !o.accepted; f++) begin
					idx = f - MIN_FACTOR;
					if (idx < N_FAC && slots_m[idx] >= o.demand) begin
						slots_m[idx] = slots_m[idx] - o.demand;
						o.accepted = 1'b1;
						o.assigned_factor = f[3:0];
						o.remaining = slots_m[idx];
					end
				end
			end else begin
				idx = int'(r.release_factor) - int'(MIN_FACTOR);
				if (idx >= 0 && r.release_factor <= TOP_FACTOR && idx < N_FAC) begin
					sum = {1'b0, slots_m[idx]} + {1'b0, o.demand};
					slots_m[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					o.accepted = 1'b1;
					o.assigned_factor = r.release_factor;
					o.remaining = slots_m[idx];
				end
			end
		end
		return o;
	endfunction

	function automatic req_t make_req(input logic [1:0] kind, input logic [15:0] reach,
			input logic [31:0] per, input logic [3:0] rfac);
		req_t r;
		r.kind = kind;
		r.distance = reach;
		r.period = per;
		r.release_factor = rfac;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int pick;
		logic [63:0] noise;
		r.distance = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 4100)) : 16'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 50) r.period = $urandom_range(101, 8000);
		else if (pick < 80) r.period = hyper_m / $urandom_range(1, 40);
		else if (pick < 92) r.period = $urandom();
		else if (pick < 96) r.period = $urandom_range(0, 100);
		else r.period = '0;
		r.release_factor = ($urandom_range(0, 99) < 85) ?
			4'($urandom_range(MIN_FACTOR, TOP_FACTOR)) : 4'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 58) begin
			r.kind = KIND_CONNECT;
		end else if (pick < 80) begin
			r.kind = KIND_RELEASE;
		end else if (pick < 86) begin
			r.kind = KIND_RELOAD;
		end else if (pick < 89) begin
			r.kind = KIND_UNUSED;
		end else begin
			noise = {$urandom(), $urandom()};
			r = noise[$bits(req_t)-1:0];
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= 50) $display("%0t: %s", $time, msg);
	endtask

	task automatic send_request(input req_t item);
		int gap;
		int pick;
		rsp_t outcome;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 55) gap = 0;
		else if (pick < 90) gap = $urandom_range(1, 3);
		else gap = $urandom_range(8, 40);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		outcome = admission_outcome(item);
		expected_q = {expected_q, outcome};
	endtask

	task automatic settle_all();
		req_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_regs(input logic [31:0] hyper, input logic [3:0] maxf);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_HYPER;
		cfg_data <= hyper;
		do @(posedge clk); while (!cfg_ready);
		hyper_m = hyper;
		cfg_index <= CFG_MAX_FACTOR;
		cfg_data <= {28'd0, maxf};
		do @(posedge clk); while (!cfg_ready);
		max_fac_m = maxf;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : stall_gen
		int pick;
		if (quiet) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				rsp_stall <= 1'b0;
			end else if (pick < 95) begin
				rsp_stall <= 1'b1;
				stall_left <= $urandom_range(0, 3);
			end else begin
				rsp_stall <= 1'b1;
				stall_left <= $urandom_range(15, 60);
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				flag_mismatch("response with no request outstanding");
			end else begin
				want = expected_q.pop_front();
				if (rsp.accepted !== want.accepted)
					flag_mismatch($sformatf("accepted got %0b expected %0b",
						rsp.accepted, want.accepted));
				if (rsp.assigned_factor !== want.assigned_factor)
					flag_mismatch($sformatf("assigned_factor got %0d expected %0d",
						rsp.assigned_factor, want.assigned_factor));
				if (rsp.demand !== want.demand)
					flag_mismatch($sformatf("demand got %0h expected %0h",
						rsp.demand, want.demand));
				if (rsp.remaining !== want.remaining)
					flag_mismatch($sformatf("remaining got %0h expected %0h",
						rsp.remaining, want.remaining));
			end
		end
	end

	task automatic test_directed();
		send_request(make_req(KIND_CONNECT, 16'd0, 32'd1024, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd0, 32'd0, 4'd0));
		send_request(make_req(KIND_RELEASE, 16'd0, 32'd0, 4'd7));
		send_request(make_req(KIND_CONNECT, 16'hFFFF, 32'd5000, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd3999, 32'd3201, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd4000, 32'd5000, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd0, 32'd100, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd124, 32'd101, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd125, 32'd101, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd0, 32'hFFFF_FFFF, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd0, 32'd1, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd1999, 32'd1601, 4'hF));
		send_request(make_req(KIND_RELEASE, 16'd0, 32'd1, 4'd12));
		send_request(make_req(KIND_RELEASE, 16'd0, 32'd1, 4'd6));
		send_request(make_req(KIND_RELEASE, 16'd0, 32'd1, 4'd13));
		send_request(make_req(KIND_RELEASE, 16'd0, 32'd1, 4'd0));
		send_request(make_req(KIND_RELEASE, 16'hFFFF, 32'd3, 4'd15));
		send_request(make_req(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 4'hF));
		send_request(make_req(KIND_RELOAD, 16'hFFFF, 32'hFFFF_FFFF, 4'hF));
		send_request(make_req(KIND_CONNECT, 16'd0, 32'd101, 4'd0));
	endtask

	task automatic test_registers();
		settle_all();
		write_regs(32'd1_000_000, 4'd12);
		repeat (6) send_request(make_req(KIND_CONNECT, 16'd0, 32'd3201, 4'd0));
		settle_all();
		write_regs(32'hFFFF_FFFF, 4'd7);
		send_request(make_req(KIND_RELOAD, 16'd0, 32'd0, 4'd0));
		send_request(make_req(KIND_RELEASE, 16'd0, 32'd1, 4'd7));
		send_request(make_req(KIND_RELEASE, 16'd0, 32'd1, 4'd7));
		send_request(make_req(KIND_CONNECT, 16'd0, 32'd3201, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd200, 32'd3201, 4'd0));
		settle_all();
		write_regs(32'd0, 4'd0);
		send_request(make_req(KIND_CONNECT, 16'd0, 32'd5000, 4'd0));
		send_request(make_req(KIND_RELOAD, 16'd0, 32'd0, 4'd0));
		settle_all();
		write_regs(32'd1, 4'd15);
		send_request(make_req(KIND_CONNECT, 16'd0, 32'd5000, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd3000, 32'd4000, 4'd0));
		send_request(make_req(KIND_RELOAD, 16'd0, 32'd0, 4'd0));
		send_request(make_req(KIND_CONNECT, 16'd0, 32'd101, 4'd0));
		send_request(make_req(KIND_RELEASE, 16'd0, 32'd1, 4'd8));
	endtask

	task automatic test_random();
		logic [31:0] hypers [6];
		logic [3:0] maxes [6];
		hypers = '{32'd1024, 32'hFFFF_FFFF, 32'd50000, $urandom(), 32'd4096, 32'd3000};
		maxes = '{4'd12, 4'd15, 4'd10, 4'd7, 4'($urandom_range(0, 15)), 4'd12};
		for (int ph = 0; ph < 6; ph++) begin
			settle_all();
			write_regs(hypers[ph], maxes[ph]);
			quiet = (ph == 2);
			send_request(make_req(KIND_RELOAD, 16'd0, 32'd0, 4'd0));
			repeat (235) send_request(random_request());
		end
		quiet = 1'b0;
	endtask

	initial begin
		hyper_m = RESET_HYPER;
		max_fac_m = RESET_MAX_FACTOR;
		refill_budgets();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		test_random();
		settle_all();
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#(64'd20_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/sfsa_pkg.sv
hdl/sfsa_div.sv
hdl/sfsa_budget.sv
hdl/spreading_factor_slot_admission.sv
bench/spreading_factor_slot_admission_tb.sv
